FILE: rtl/osc_mp_pkg.sv
package osc_mp_pkg;

  // Limits on kept address segments and stored argument tags.
  localparam int MaxSegments = 4;
  localparam int MaxArgs     = 8;

  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharNull  = 8'h00;

  typedef enum logic [2:0] {
    PhAddr    = 3'd0,
    PhAddrPad = 3'd1,
    PhTags    = 3'd2,
    PhTagPad  = 3'd3,
    PhArgs    = 3'd4,
    PhDone    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    KChar   = 3'd0,
    KSegEnd = 3'd1,
    KTag    = 3'd2,
    KWord   = 3'd3,
    KEmpty  = 3'd4
  } kind_e;

  // Parser context carried from one byte to the next.
  typedef struct packed {
    phase_e      phase;
    logic [1:0]  byte_offset;
    logic        at_head;
    logic [3:0]  seg_count;
    logic [4:0]  tag_count;
    logic [4:0]  arg_count;
    logic [23:0] word_acc;
  } state_t;

  localparam state_t StateReset = '{
    phase:       PhAddr,
    byte_offset: 2'd0,
    at_head:     1'b1,
    seg_count:   4'd0,
    tag_count:   5'd0,
    arg_count:   5'd0,
    word_acc:    24'd0
  };

  // One decoded item, with a flag that says whether the byte produced one.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

FILE: rtl/osc_mp_step.sv
module osc_mp_step (
  input  osc_mp_pkg::state_t  state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                packet_start_i,
  output osc_mp_pkg::state_t  state_o,
  output osc_mp_pkg::result_t result_o
);
  import osc_mp_pkg::*;

  state_t     cur;
  logic [1:0] next_off;
  logic       seg_room;
  logic       tag_room;
  logic       last_word;

  always_comb begin
    // A packet start restarts the parser before the byte is handled.
    cur       = packet_start_i ? StateReset : state_i;
    next_off  = cur.byte_offset + 2'd1;
    seg_room  = cur.seg_count < 4'(MaxSegments);
    tag_room  = cur.tag_count < 5'(MaxArgs);
    last_word = ({1'b0, cur.arg_count} + 6'd1) >= {1'b0, cur.tag_count};

    state_o          = cur;
    state_o.at_head  = 1'b0;
    result_o         = '0;
    result_o.kind    = KChar;

    if (cur.phase != PhDone) begin
      state_o.byte_offset = next_off;
    end

    unique case (cur.phase)
      PhAddr: begin
        if (data_byte_i == CharNull) begin
          if (seg_room) begin
            result_o.valid    = 1'b1;
            result_o.kind     = KSegEnd;
            result_o.index    = cur.seg_count;
            state_o.seg_count = cur.seg_count + 4'd1;
          end
          state_o.phase = (next_off == 2'd0) ? PhTags : PhAddrPad;
        end else if (data_byte_i == CharSlash) begin
          // A slash at the very first byte only opens the address.
          if (!cur.at_head && seg_room) begin
            result_o.valid    = 1'b1;
            result_o.kind     = KSegEnd;
            result_o.index    = cur.seg_count;
            state_o.seg_count = cur.seg_count + 4'd1;
          end
        end else if (seg_room) begin
          result_o.valid = 1'b1;
          result_o.kind  = KChar;
          result_o.index = cur.seg_count;
          result_o.value = {24'd0, data_byte_i};
        end
      end
      PhAddrPad: begin
        if (next_off == 2'd0) begin
          state_o.phase = PhTags;
        end
      end
      PhTags: begin
        if (data_byte_i == CharNull) begin
          if (cur.tag_count == 5'd0) begin
            result_o.valid = 1'b1;
            result_o.kind  = KEmpty;
            result_o.last  = 1'b1;
            state_o.phase  = PhDone;
          end else begin
            state_o.phase = (next_off == 2'd0) ? PhArgs : PhTagPad;
          end
        end else if (data_byte_i != CharComma && tag_room) begin
          result_o.valid    = 1'b1;
          result_o.kind     = KTag;
          result_o.index    = cur.tag_count[3:0];
          result_o.value    = {24'd0, data_byte_i};
          state_o.tag_count = cur.tag_count + 5'd1;
        end
      end
      PhTagPad: begin
        if (next_off == 2'd0) begin
          state_o.phase = PhArgs;
        end
      end
      PhArgs: begin
        if (cur.byte_offset != 2'd3) begin
          state_o.word_acc = {cur.word_acc[15:0], data_byte_i};
        end else begin
          result_o.valid    = 1'b1;
          result_o.kind     = KWord;
          result_o.index    = cur.arg_count[3:0];
          result_o.value    = {cur.word_acc, data_byte_i};
          result_o.last     = last_word;
          state_o.word_acc  = 24'd0;
          state_o.arg_count = cur.arg_count + 5'd1;
          if (last_word) begin
            state_o.phase = PhDone;
          end
        end
      end
      PhDone: begin
        state_o.phase = PhDone;
      end
      default: begin
        state_o.phase = PhDone;
      end
    endcase
  end

endmodule

FILE: rtl/osc_message_parser.sv
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_stall_o  data_byte_i, packet_start_i
// out      source     out_valid_o / out_stall_i kind_o, item_index_o, item_value_o,
//                                              message_end_o
//
// A byte's result goes through the input and the output register: the byte is
// accepted into the input register and sits there while the decode step works
// on it, and the result is loaded into the output register when the step runs.
// One byte is accepted every cycle while the output side keeps taking results.
// Reset returns the parser to the start of the address and empties both
// registers. A stalled output holds its request and stops the decode step; the
// input stalls only while its register is full and cannot move on.
module osc_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  item_index_o,
  output logic [31:0] item_value_o,
  output logic        message_end_o
);
  import osc_mp_pkg::*;

  // Input register holding one accepted byte.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // Parser context, advanced once for every byte that passes the decode step.
  state_t  state_q, state_d;
  result_t result;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_kind_q;
  logic [3:0]  out_index_q;
  logic [31:0] out_value_q;
  logic        out_last_q;

  logic in_take;
  logic step_go;

  // The decode step may run when the output register is empty or is being
  // emptied in this cycle; a byte with no result simply updates the context.
  assign step_go    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step_go;
  assign in_take    = in_valid_i && !in_stall_o;

  osc_mp_step u_step (
    .state_i        (state_q),
    .data_byte_i    (in_byte_q),
    .packet_start_i (in_start_q),
    .state_o        (state_d),
    .result_o       (result)
  );

  always_comb begin
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step_go) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (step_go) begin
      out_valid_d = result.valid;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step_go) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= packet_start_i;
    end
    if (step_go && result.valid) begin
      out_kind_q  <= result.kind;
      out_index_q <= result.index;
      out_value_q <= result.value;
      out_last_q  <= result.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign item_index_o  = out_index_q;
  assign item_value_o  = out_value_q;
  assign message_end_o = out_last_q;

  // The message end flag only closes a message on an argument word or an
  // empty-message marker.
  a_end_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> (kind_o == KWord || kind_o == KEmpty))
    else $error("message end on a wrong kind");

  // Address items never carry a segment index past the kept limit.
  a_seg_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KChar || kind_o == KSegEnd)
      |-> item_index_o < 4'(MaxSegments))
    else $error("segment index out of range");

  // Stored tag count never exceeds the argument limit.
  a_tag_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tag_count <= 5'(MaxArgs))
    else $error("too many stored tags");

  // The input stalls only while its register holds a byte that cannot move.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without cause");

  // A byte held in the input register while the output is free is decoded
  // and leaves the register unless a new byte replaces it.
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q && !in_take |=> !in_valid_q)
    else $error("input register did not drain");

endmodule

FILE: tb/sv/osc_message_parser_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the OSC message parser. Bytes go in one request at a
// time, and every result that comes out is compared field by field with the
// oldest entry of a queue that a local copy of the parser fills. Both sides
// idle at random, except in one stretch where bytes and results move back to
// back.
module osc_message_parser_tb;
  import osc_mp_pkg::*;

  // One decoded result as the bench expects to see it.
  typedef struct {
    kind_e       kind;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
  } osc_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        packet_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [3:0]  item_index_o;
  logic [31:0] item_value_o;
  logic        message_end_o;

  osc_message_parser uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .item_index_o   (item_index_o),
    .item_value_o   (item_value_o),
    .message_end_o  (message_end_o)
  );

  // Results still owed by the parser, oldest first.
  osc_item_t pending_items[$];
  // Bytes of the packet that the current test is about to send.
  logic [7:0] pkt_bytes[$];

  int errors;
  int results_checked;
  int bytes_parsed;
  int messages_sent;
  // While set, neither side inserts idle cycles.
  bit no_idle;

  // The bench's own copy of the parser state.
  phase_e      prs_phase;
  logic [1:0]  prs_offset;
  logic        prs_head;
  logic [3:0]  prs_segs;
  logic [4:0]  prs_tags;
  logic [4:0]  prs_arg;
  logic [23:0] prs_acc;

  osc_item_t seen_want;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic void reset_decoder();
    prs_phase  = PhAddr;
    prs_offset = 2'd0;
    prs_head   = 1'b1;
    prs_segs   = 4'd0;
    prs_tags   = 5'd0;
    prs_arg    = 5'd0;
    prs_acc    = 24'd0;
  endfunction

  // Advances the local parser by one byte. Returns 1 when the byte yields a
  // result, which is then left in item.
  function automatic bit decode_osc_byte(input logic [7:0] d, input logic start,
                                         output osc_item_t item);
    logic       head;
    logic [1:0] pos;
    bit         hit;
    bit         last;
    hit        = 1'b0;
    item.kind  = KChar;
    item.index = 4'd0;
    item.value = 32'd0;
    item.last  = 1'b0;
    if (start) begin
      reset_decoder();
    end
    head     = prs_head;
    prs_head = 1'b0;
    // A finished message ignores everything until the next packet start.
    if (prs_phase == PhDone) begin
      return 1'b0;
    end
    pos        = prs_offset;
    prs_offset = prs_offset + 2'd1;
    case (prs_phase)
      PhAddr: begin
        if (d == CharNull) begin
          // The terminator closes the last kept segment, then we align.
          if (prs_segs < MaxSegments) begin
            item.kind  = KSegEnd;
            item.index = prs_segs;
            hit        = 1'b1;
            prs_segs   = prs_segs + 4'd1;
          end
          prs_phase = (prs_offset == 2'd0) ? PhTags : PhAddrPad;
        end else if (d == CharSlash) begin
          // A slash at the very first byte of the packet is just the root.
          if (!head && prs_segs < MaxSegments) begin
            item.kind  = KSegEnd;
            item.index = prs_segs;
            hit        = 1'b1;
            prs_segs   = prs_segs + 4'd1;
          end
        end else if (prs_segs < MaxSegments) begin
          item.kind  = KChar;
          item.index = prs_segs;
          item.value = {24'd0, d};
          hit        = 1'b1;
        end
      end
      PhAddrPad: begin
        if (prs_offset == 2'd0) begin
          prs_phase = PhTags;
        end
      end
      PhTags: begin
        if (d == CharNull) begin
          if (prs_tags == 5'd0) begin
            // No tags at all: the message ends right here.
            item.kind = KEmpty;
            item.last = 1'b1;
            hit       = 1'b1;
            prs_phase = PhDone;
          end else begin
            prs_phase = (prs_offset == 2'd0) ? PhArgs : PhTagPad;
          end
        end else if (d != CharComma) begin
          if (prs_tags < MaxArgs) begin
            item.kind  = KTag;
            item.index = prs_tags[3:0];
            item.value = {24'd0, d};
            hit        = 1'b1;
            prs_tags   = prs_tags + 5'd1;
          end
        end
      end
      PhTagPad: begin
        if (prs_offset == 2'd0) begin
          prs_phase = PhArgs;
        end
      end
      PhArgs: begin
        if (pos != 2'd3) begin
          prs_acc = {prs_acc[15:0], d};
        end else begin
          // The fourth byte completes a big-endian word.
          last       = (int'(prs_arg) + 1) >= int'(prs_tags);
          item.kind  = KWord;
          item.index = prs_arg[3:0];
          item.value = {prs_acc, d};
          item.last  = last;
          hit        = 1'b1;
          prs_acc    = 24'd0;
          prs_arg    = prs_arg + 5'd1;
          if (last) begin
            prs_phase = PhDone;
          end
        end
      end
      default: begin
        prs_phase = PhDone;
      end
    endcase
    return hit;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Drives one request and holds it until the parser takes it. The caller
  // must be at a rising edge; on return we are again at a rising edge, with
  // valid still high when no gap follows so that the next byte can go at once.
  task automatic send_byte(input logic [7:0] d, input logic start);
    osc_item_t item;
    int gap;
    in_valid_i     <= 1'b1;
    data_byte_i    <= d;
    packet_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    // Bytes swallowed after the end of a message are not counted as work.
    if (start || prs_phase != PhDone) begin
      bytes_parsed++;
    end
    if (decode_osc_byte(d, start, item)) begin
      pending_items.push_back(item);
    end
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends the first cut bytes of pkt_bytes, flagging the first as the start.
  task automatic send_packet(input int cut);
    for (int i = 0; i < pkt_bytes.size() && i < cut; i++) begin
      send_byte(pkt_bytes[i], i == 0);
    end
    messages_sent++;
  endtask

  // Padding value does not matter to the parser, so it is sometimes garbage.
  task automatic pad_to_word();
    while (pkt_bytes.size() % 4 != 0) begin
      pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CharNull);
    end
  endtask

  function automatic logic [7:0] address_char();
    if ($urandom_range(0, 7) == 0) begin
      return 8'($urandom_range(1, 255));
    end
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  function automatic logic [7:0] tag_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) begin
      return 8'($urandom_range(8'h61, 8'h7a));
    end
    c = 8'($urandom_range(1, 255));
    while (c == CharComma) begin
      c = 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] argument_byte();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hff;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds a well-formed message with random content into pkt_bytes. The
  // segment and tag counts sometimes exceed what the parser keeps.
  task automatic build_message();
    int nseg;
    int len;
    int ntags;
    int stored;
    pkt_bytes.delete();
    if ($urandom_range(0, 3) != 0) begin
      pkt_bytes.push_back(CharSlash);
    end
    nseg = $urandom_range(0, 6);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) begin
        pkt_bytes.push_back(CharSlash);
      end
      len = $urandom_range(0, 4);
      repeat (len) pkt_bytes.push_back(address_char());
    end
    pkt_bytes.push_back(CharNull);
    pad_to_word();
    if ($urandom_range(0, 9) == 0) begin
      // No type tag string: a null sits where the comma should be.
      pkt_bytes.push_back(CharNull);
      pad_to_word();
    end else begin
      pkt_bytes.push_back(CharComma);
      ntags = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
      stored = 0;
      for (int i = 0; i < ntags; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          pkt_bytes.push_back(CharComma);
        end
        pkt_bytes.push_back(tag_char());
        stored++;
      end
      pkt_bytes.push_back(CharNull);
      pad_to_word();
      if (stored > MaxArgs) begin
        stored = MaxArgs;
      end
      repeat (stored * 4) pkt_bytes.push_back(argument_byte());
    end
    // Occasional trailing bytes that the parser must ignore.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Hand-picked packets: an empty tag list behind a one-character address, an
  // address without leading slash followed by a missing tag string and a
  // stray byte, and a root-only address with a single all-ones argument word.
  task automatic test_directed();
    pkt_bytes = '{8'h2f, 8'h61, 8'h00, 8'h00, 8'h2c, 8'h00, 8'h00, 8'h00};
    send_packet(pkt_bytes.size());
    pkt_bytes = '{8'hff, 8'h2f, 8'h00, 8'h00, 8'h00, 8'h5a};
    send_packet(pkt_bytes.size());
    pkt_bytes = '{8'h2f, 8'h00, 8'h00, 8'h00, 8'h2c, 8'h69, 8'h00, 8'h00,
                  8'hff, 8'hff, 8'hff, 8'hff};
    send_packet(pkt_bytes.size());
  endtask

  task automatic test_well_formed(input int upto);
    while (bytes_parsed < upto) begin
      build_message();
      send_packet(pkt_bytes.size());
    end
  endtask

  // Same traffic with both sides always ready, to run the pipe at full rate.
  task automatic test_back_to_back(input int upto);
    no_idle = 1'b1;
    test_well_formed(upto);
    no_idle = 1'b0;
  endtask

  // Packets cut short anywhere; the next start has to recover the parser.
  task automatic test_truncated(input int upto);
    while (bytes_parsed < upto) begin
      build_message();
      send_packet($urandom_range(1, pkt_bytes.size()));
    end
  endtask

  // Raw random bytes with a rare packet start.
  task automatic test_noise(input int upto);
    while (bytes_parsed < upto) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end
  endtask

  // Result checker: every result taken from the parser is matched against the
  // oldest expectation. Outputs are sampled at the edge, before any update.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_items.size() == 0) begin
        report_mismatch("result with nothing expected, value", item_value_o, 32'd0);
      end else begin
        seen_want = pending_items.pop_front();
        results_checked++;
        if (kind_o !== seen_want.kind) begin
          report_mismatch("kind", {29'd0, kind_o}, {29'd0, seen_want.kind});
        end
        if (item_index_o !== seen_want.index) begin
          report_mismatch("item_index", {28'd0, item_index_o}, {28'd0, seen_want.index});
        end
        if (item_value_o !== seen_want.value) begin
          report_mismatch("item_value", item_value_o, seen_want.value);
        end
        if (message_end_o !== seen_want.last) begin
          report_mismatch("message_end", {31'd0, message_end_o}, {31'd0, seen_want.last});
        end
      end
    end
  end

  // Output back-pressure: random stall bursts between short ready stretches.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int guard;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'd0;
    packet_start_i  = 1'b0;
    errors          = 0;
    results_checked = 0;
    bytes_parsed    = 0;
    messages_sent   = 0;
    no_idle         = 1'b0;
    reset_decoder();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_well_formed(1000);
    test_back_to_back(1150);
    test_truncated(1350);
    test_noise(1550);

    // Let the pipe drain: wait for the last result, then go on waiting in case
    // something unexpected is still on its way out.
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_items.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_items.size() != 0) begin
      report_mismatch("results never delivered, count", pending_items.size(), 32'd0);
    end

    $display("Sent %0d packets (%0d bytes parsed): directed, well-formed, back-to-back,",
             messages_sent, bytes_parsed);
    $display("truncated and noise traffic; %0d results compared, %0d mismatches.",
             results_checked, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/osc_mp_pkg.sv
rtl/osc_mp_step.sv
rtl/osc_message_parser.sv
tb/sv/osc_message_parser_tb.sv
